FILE: design/battery_coulomb_counter_macros.svh
// ----------------------------------------------------------------------------
// battery coulomb counter assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef BATTERY_COULOMB_COUNTER_MACROS_SVH
`define BATTERY_COULOMB_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

`define BCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bcc assertion failed");

`define BCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bcc assertion failed");

`else

`define BCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define BCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// types and constants of the battery coulomb counter
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int OP_W       = 2;
    localparam int TS_W       = 32;
    localparam int VAL_W      = 20;
    localparam int CAP_W      = 20;
    localparam int MV_W       = 16;
    localparam int TGT_W      = 15;
    localparam int GAP_W      = 16;
    localparam int HOLD_W     = 20;
    localparam int SOC_W      = 10;
    localparam int TOT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int VOLT_W     = 19;
    localparam int STAGE_W    = 4;
    localparam int CHG_W      = 49;
    localparam int ACC_W      = 64;
    localparam int QUO_W      = 36;
    localparam int MAG_W      = 27;
    localparam int EFF_W      = 7;
    localparam int CNT_W      = 6;

    localparam logic [OP_W-1:0] OP_CURRENT = 2'd0;
    localparam logic [OP_W-1:0] OP_VOLTAGE = 2'd1;
    localparam logic [OP_W-1:0] OP_STAGE   = 2'd2;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_MV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSORB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd5;

    localparam logic [CAP_W-1:0]  CAP_MIN     = 20'd5000;
    localparam logic [MV_W-1:0]   LOW_MV_MIN  = 16'd18000;
    localparam logic [TGT_W-1:0]  TGT_MIN     = 15'd20000;
    localparam logic [TGT_W-1:0]  TGT_MAX     = 15'd32000;

    localparam logic [CAP_W-1:0]  CAP_RST     = 20'd100000;
    localparam logic [MV_W-1:0]   LOW_MV_RST  = 16'd21000;
    localparam logic [TGT_W-1:0]  FLOAT_RST   = 15'd27000;
    localparam logic [TGT_W-1:0]  ABSORB_RST  = 15'd28400;
    localparam logic [GAP_W-1:0]  GAP_RST     = 16'd30000;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 20'd60000;

    // charge unit is 0.01 mA*ms
    localparam logic [CHG_W-1:0] UNITS_PER_MAH = 49'd360000000;
    localparam logic [CHG_W-1:0] CAP_UNITS_RST = 49'd36000000000000;
    localparam logic [CHG_W-1:0] REM_RST       = 49'd18000000000000;
    localparam logic [CHG_W-1:0] TEN_MAH       = 49'd3600000000;
    localparam logic [CHG_W-1:0] CUT_MIN_CHG   = 49'd180000000000;

    localparam logic signed [VAL_W-1:0] DEADZONE_MA = 20'sd50;
    localparam logic signed [VAL_W-1:0] I_MID_MA    = 20'sd15000;
    localparam logic signed [VAL_W-1:0] I_HIGH_MA   = 20'sd40000;
    localparam logic signed [VAL_W-1:0] FULL_I_MA   = 20'sd1000;
    localparam logic signed [VAL_W-1:0] CUT_I_MA    = 20'sd500;
    localparam logic signed [VAL_W-1:0] STAGE_MAX_S = 20'sd15;

    localparam logic [EFF_W-1:0] EFF_LOW  = 7'd102;
    localparam logic [EFF_W-1:0] EFF_MID  = 7'd106;
    localparam logic [EFF_W-1:0] EFF_HIGH = 7'd112;
    localparam logic [EFF_W-1:0] EFF_CHG  = 7'd98;

    localparam logic [STAGE_W-1:0] STAGE_FLOAT  = 4'd2;
    localparam logic [STAGE_W-1:0] STAGE_ABSORB = 4'd3;
    localparam logic [STAGE_W-1:0] STAGE_BAD    = 4'd15;

    localparam logic [VAL_W:0]   VOLT_MARGIN = 21'd200;
    localparam logic [SOC_W-1:0] SOC_FULL    = 10'd1000;

    // quotient bits of the remaining, permille and total serial divisions
    localparam int REM_QB = 21;
    localparam int SOC_QB = 11;
    localparam int TOT_QB = 36;

    localparam logic [CNT_W-1:0] MUL_STEPS = 6'd20;
    localparam logic [CNT_W-1:0] REM_STEPS = 6'd21;
    localparam logic [CNT_W-1:0] SOC_STEPS = 6'd11;
    localparam logic [CNT_W-1:0] TOT_STEPS = 6'd36;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAP_MUL,
        S_CLAMP,
        S_WIN,
        S_AVG_DIV,
        S_INTEG,
        S_DQ_MUL,
        S_APPLY,
        S_MISC,
        S_REM_DIV,
        S_SOC_DIV,
        S_CHG_DIV,
        S_DIS_DIV,
        S_DONE
    } t_state;

endpackage

FILE: design/bcc_if.sv
// ----------------------------------------------------------------------------
// bcc channel interfaces
// input word, result word and register write channels
// ----------------------------------------------------------------------------
interface bcc_in_if import bcc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [TS_W-1:0]         timestamp_ms;
    logic signed [VAL_W-1:0] sample_value;

    modport source (output valid, operation, timestamp_ms, sample_value, input ready);
    modport sink (input valid, operation, timestamp_ms, sample_value, output ready);
endinterface

interface bcc_out_if import bcc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CAP_W-1:0]        remaining_mah;
    logic [SOC_W-1:0]        soc_permille;
    logic signed [VAL_W-1:0] filtered_current_ma;
    logic [TOT_W-1:0]        charged_mah;
    logic [TOT_W-1:0]        discharged_mah;
    logic                    calibrated_full;
    logic                    cutoff_empty;

    modport source (output valid, remaining_mah, soc_permille, filtered_current_ma,
                    charged_mah, discharged_mah, calibrated_full, cutoff_empty,
                    input ready);
    modport sink (input valid, remaining_mah, soc_permille, filtered_current_ma,
                  charged_mah, discharged_mah, calibrated_full, cutoff_empty,
                  output ready);
endinterface

interface bcc_cfg_if import bcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/battery_coulomb_counter.sv
// ----------------------------------------------------------------------------
// battery_coulomb_counter
// coulomb counting fuel gauge with moving average, tiered efficiency and
// full and empty calibration
// ----------------------------------------------------------------------------
// one word in, one result word out. the block takes a word, works on it alone
// and then holds the result until it is taken; the next word is accepted
// once the result is gone. a current word also averages the window, dividing
// the window sum, whose width is set by AVG_TAPS (24 bits at 5 taps), and
// multiplies in the charge when the gap is integrated. the first word after a
// capacity write also runs the capacity-to-charge multiply. a bit-serial
// divider produces the average and the mAh, permille and total outputs.
// registers are written only while idle; invalid capacity, cutoff or
// setpoint values are dropped.
// ----------------------------------------------------------------------------
`include "battery_coulomb_counter_macros.svh"

module battery_coulomb_counter import bcc_pkg::*; #(
    parameter int AVG_TAPS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcc_cfg_if.sink    i_cfg,
    bcc_in_if.sink     i_in,
    bcc_out_if.source  o_out
);

    localparam int PW = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
    localparam int CW = $clog2(AVG_TAPS + 1);
    localparam int SW = VAL_W + $clog2(AVG_TAPS) + 1;
    localparam logic [CW-1:0]    TAPS_C    = CW'(AVG_TAPS);
    localparam logic [PW-1:0]    LAST_POS  = PW'(AVG_TAPS - 1);
    localparam logic [CNT_W-1:0] AVG_STEPS = CNT_W'(SW);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    logic [CAP_W-1:0]  r_cap_mah;
    logic [MV_W-1:0]   r_low_mv;
    logic [TGT_W-1:0]  r_float_mv;
    logic [TGT_W-1:0]  r_absorb_mv;
    logic [GAP_W-1:0]  r_max_gap;
    logic [HOLD_W-1:0] r_hold;
    logic              r_cap_dirty;
    logic [CHG_W-1:0]  r_cap_units;

    logic [OP_W-1:0]         r_op;
    logic [TS_W-1:0]         r_ts;
    logic signed [VAL_W-1:0] r_val;

    logic signed [VAL_W-1:0] r_win [AVG_TAPS];
    logic [CW-1:0]           r_wcount;
    logic [PW-1:0]           r_wpos;
    logic signed [SW-1:0]    r_wsum;
    logic signed [VAL_W-1:0] r_avg;

    logic [CHG_W-1:0]   r_rem;
    logic [ACC_W-1:0]   r_chg;
    logic [ACC_W-1:0]   r_dis;
    logic [TS_W-1:0]    r_last_ts;
    logic               r_seen;
    logic [VOLT_W-1:0]  r_volt;
    logic               r_vseen;
    logic [STAGE_W-1:0] r_stage;
    logic               r_fpend;
    logic [TS_W-1:0]    r_fstart;
    logic               r_cal;
    logic               r_cut;

    // serial divider and multiplier
    logic [CHG_W-1:0] r_dpart;
    logic [ACC_W-1:0] r_dnum;
    logic [CHG_W-1:0] r_dden;
    logic [QUO_W-1:0] r_dquo;
    logic             r_dneg;
    logic [CHG_W-1:0] r_mcand;
    logic [CAP_W-1:0] r_mplier;
    logic [CHG_W-1:0] r_macc;
    logic [MAG_W-1:0] r_mag;
    logic [GAP_W-1:0] r_dt;
    logic             r_ipos;

    logic [CAP_W-1:0]  r_out_rem;
    logic [SOC_W-1:0]  r_out_soc;
    logic [TOT_W-1:0]  r_out_chg;

    logic in_acc, cfg_acc, ld;
    logic in_ready, out_valid, cfg_ready;

    logic [CHG_W:0]   d_t;
    logic             d_ge;
    logic [CHG_W:0]   d_diff;

    logic [TS_W-1:0]         dt;
    logic                    integ_ok;
    logic [VAL_W-1:0]        q20;
    logic signed [VAL_W-1:0] avg_new;
    logic signed [VAL_W-1:0] i_dz;
    logic [VAL_W-1:0]        i_mag;
    logic [EFF_W-1:0]        eff;
    logic [SW-1:0]           sum_mag;
    logic [ACC_W-1:0]        rem_k;
    logic [CHG_W-1:0]        cap_now;
    logic [VOLT_W-1:0]       v_store;
    logic                    cut_hit;
    logic [TGT_W-1:0]        target;
    logic                    full_ok;
    logic [CHG_W:0]          chg_sum;
    logic [ACC_W:0]          tot_sum_c;
    logic [ACC_W:0]          tot_sum_d;
    logic [TOT_W-1:0]        out_dis;

    assign in_acc  = i_in.valid && in_ready;
    assign cfg_acc = i_cfg.valid && cfg_ready;
    assign ld      = (r_cnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = r_cap_dirty ? S_CAP_MUL : S_CLAMP;
            end
            S_CAP_MUL: begin
                if (r_cnt == MUL_STEPS) n_state = S_CLAMP;
            end
            S_CLAMP:   n_state = (r_op == OP_CURRENT) ? S_WIN : S_MISC;
            S_WIN:     n_state = S_AVG_DIV;
            S_AVG_DIV: begin
                if (r_cnt == AVG_STEPS) n_state = S_INTEG;
            end
            S_INTEG:   n_state = integ_ok ? S_DQ_MUL : S_REM_DIV;
            S_DQ_MUL: begin
                if (r_cnt == MUL_STEPS) n_state = S_APPLY;
            end
            S_APPLY:   n_state = S_REM_DIV;
            S_MISC:    n_state = S_REM_DIV;
            S_REM_DIV: begin
                if (r_cnt == REM_STEPS) n_state = S_SOC_DIV;
            end
            S_SOC_DIV: begin
                if (r_cnt == SOC_STEPS) n_state = S_CHG_DIV;
            end
            S_CHG_DIV: begin
                if (r_cnt == TOT_STEPS) n_state = S_DIS_DIV;
            end
            S_DIS_DIV: begin
                if (r_cnt == TOT_STEPS) n_state = S_DONE;
            end
            S_DONE: begin
                if (o_out.ready) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready  = 1'b1;
                cfg_ready = !i_in.valid;
            end
            S_DONE:  out_valid = 1'b1;
            default: begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
                cfg_ready = 1'b0;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        d_t    = {r_dpart, r_dnum[ACC_W-1]};
        d_ge   = (d_t >= {1'b0, r_dden});
        d_diff = d_t - {1'b0, r_dden};

        dt       = r_ts - r_last_ts;
        integ_ok = r_seen && (dt != '0) && (dt <= TS_W'(r_max_gap));

        q20     = r_dquo[VAL_W-1:0];
        avg_new = r_dneg ? signed'(-q20) : signed'(q20);
        i_dz    = (avg_new > -DEADZONE_MA && avg_new < DEADZONE_MA) ? '0 : avg_new;
        i_mag   = i_dz[VAL_W-1] ? (~i_dz + 1'b1) : i_dz;
        if (i_dz > 0) begin
            if (i_dz > I_HIGH_MA) eff = EFF_HIGH;
            else if (i_dz > I_MID_MA) eff = EFF_MID;
            else eff = EFF_LOW;
        end else begin
            eff = EFF_CHG;
        end

        sum_mag = r_wsum[SW-1] ? SW'(-r_wsum) : SW'(r_wsum);
        rem_k   = (ACC_W'(r_rem) << 10) - (ACC_W'(r_rem) << 4) - (ACC_W'(r_rem) << 3);
        cap_now = r_cap_dirty ? r_macc : r_cap_units;

        v_store = r_val[VAL_W-1] ? '0 : r_val[VOLT_W-1:0];
        cut_hit = ((VAL_W+1)'(v_store) + VOLT_MARGIN <= (VAL_W+1)'(r_low_mv))
                  && (r_avg > CUT_I_MA) && (r_rem > CUT_MIN_CHG);

        target  = (r_stage == STAGE_FLOAT) ? r_float_mv : r_absorb_mv;
        full_ok = ((r_stage == STAGE_FLOAT) || (r_stage == STAGE_ABSORB))
                  && (r_avg <= FULL_I_MA) && (r_avg >= -FULL_I_MA) && r_vseen
                  && ((VAL_W+1)'(r_volt) + VOLT_MARGIN >= (VAL_W+1)'(target))
                  && ({1'b0, r_rem} + {1'b0, TEN_MAH} < {1'b0, r_cap_units});

        chg_sum   = {1'b0, r_rem} + {1'b0, r_macc};
        tot_sum_c = {1'b0, r_chg} + (ACC_W+1)'(r_macc);
        tot_sum_d = {1'b0, r_dis} + (ACC_W+1)'(r_macc);
        out_dis   = (r_dquo[QUO_W-1:TOT_W] != '0) ? '1 : r_dquo[TOT_W-1:0];
    end

    // control, registers and gauge state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cap_mah   <= CAP_RST;
            r_low_mv    <= LOW_MV_RST;
            r_float_mv  <= FLOAT_RST;
            r_absorb_mv <= ABSORB_RST;
            r_max_gap   <= GAP_RST;
            r_hold      <= HOLD_RST;
            r_cap_dirty <= 1'b0;
            r_cap_units <= CAP_UNITS_RST;
            for (int k = 0; k < AVG_TAPS; k++) r_win[k] <= '0;
            r_wcount    <= '0;
            r_wpos      <= '0;
            r_wsum      <= '0;
            r_avg       <= '0;
            r_rem       <= REM_RST;
            r_chg       <= '0;
            r_dis       <= '0;
            r_last_ts   <= '0;
            r_seen      <= 1'b0;
            r_volt      <= '0;
            r_vseen     <= 1'b0;
            r_stage     <= '0;
            r_fpend     <= 1'b0;
            r_fstart    <= '0;
            r_cal       <= 1'b0;
            r_cut       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cal <= 1'b0;
                        r_cut <= 1'b0;
                    end
                end
                S_CLAMP: begin
                    r_cap_units <= cap_now;
                    r_cap_dirty <= 1'b0;
                    if (r_rem > cap_now) r_rem <= cap_now;
                end
                S_WIN: begin
                    r_wsum        <= r_wsum - SW'(r_win[r_wpos]) + SW'(r_val);
                    r_win[r_wpos] <= r_val;
                    r_wpos        <= (r_wpos == LAST_POS) ? '0 : r_wpos + 1'b1;
                    if (r_wcount < TAPS_C) r_wcount <= r_wcount + 1'b1;
                end
                S_INTEG: begin
                    r_avg     <= avg_new;
                    r_last_ts <= r_ts;
                    r_seen    <= 1'b1;
                end
                S_APPLY: begin
                    if (r_ipos) begin
                        r_rem <= (r_macc > r_rem) ? '0 : r_rem - r_macc;
                        r_dis <= tot_sum_d[ACC_W] ? '1 : tot_sum_d[ACC_W-1:0];
                    end else begin
                        r_rem <= (chg_sum > {1'b0, r_cap_units}) ? r_cap_units
                                                                  : chg_sum[CHG_W-1:0];
                        r_chg <= tot_sum_c[ACC_W] ? '1 : tot_sum_c[ACC_W-1:0];
                    end
                end
                S_MISC: begin
                    case (r_op)
                        OP_VOLTAGE: begin
                            r_volt  <= v_store;
                            r_vseen <= 1'b1;
                            if (cut_hit) begin
                                r_rem <= '0;
                                r_cut <= 1'b1;
                            end
                        end
                        OP_STAGE: begin
                            if (r_val[VAL_W-1] || r_val > STAGE_MAX_S) r_stage <= STAGE_BAD;
                            else r_stage <= r_val[STAGE_W-1:0];
                        end
                        OP_CHECK: begin
                            if (full_ok) begin
                                if (!r_fpend) begin
                                    r_fpend  <= 1'b1;
                                    r_fstart <= r_ts;
                                end else if ((r_ts - r_fstart) >= TS_W'(r_hold)) begin
                                    r_rem    <= r_cap_units;
                                    r_fpend  <= 1'b0;
                                    r_fstart <= '0;
                                    r_cal    <= 1'b1;
                                end
                            end else begin
                                r_fpend  <= 1'b0;
                                r_fstart <= '0;
                            end
                        end
                        default: begin
                            r_fpend <= r_fpend;
                        end
                    endcase
                end
                default: begin
                    r_cal <= r_cal;
                end
            endcase
            if (cfg_acc) begin
                case (i_cfg.index)
                    CFG_CAPACITY: begin
                        if (i_cfg.data >= CAP_MIN) begin
                            r_cap_mah   <= i_cfg.data;
                            r_cap_dirty <= 1'b1;
                        end
                    end
                    CFG_LOW_MV: begin
                        if (i_cfg.data[MV_W-1:0] >= LOW_MV_MIN)
                            r_low_mv <= i_cfg.data[MV_W-1:0];
                    end
                    CFG_FLOAT_MV: begin
                        if (i_cfg.data[TGT_W-1:0] >= TGT_MIN && i_cfg.data[TGT_W-1:0] <= TGT_MAX)
                            r_float_mv <= i_cfg.data[TGT_W-1:0];
                    end
                    CFG_ABSORB: begin
                        if (i_cfg.data[TGT_W-1:0] >= TGT_MIN && i_cfg.data[TGT_W-1:0] <= TGT_MAX)
                            r_absorb_mv <= i_cfg.data[TGT_W-1:0];
                    end
                    CFG_MAX_GAP: r_max_gap <= i_cfg.data[GAP_W-1:0];
                    CFG_HOLD:    r_hold    <= i_cfg.data[HOLD_W-1:0];
                    default:     r_hold    <= r_hold;
                endcase
            end
        end
    end

    // bit-serial divider, multiplier and result words
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_in.operation;
            r_ts  <= i_in.timestamp_ms;
            r_val <= i_in.sample_value;
        end
        case (r_state)
            S_CAP_MUL, S_DQ_MUL: begin
                if (ld) begin
                    r_macc <= '0;
                    if (r_state == S_CAP_MUL) begin
                        r_mcand  <= UNITS_PER_MAH;
                        r_mplier <= r_cap_mah;
                    end else begin
                        r_mcand  <= CHG_W'(r_mag);
                        r_mplier <= CAP_W'(r_dt);
                    end
                end else begin
                    if (r_mplier[0]) r_macc <= r_macc + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            S_INTEG: begin
                r_mag  <= MAG_W'(i_mag) * MAG_W'(eff);
                r_ipos <= (i_dz > 0);
                r_dt   <= dt[GAP_W-1:0];
            end
            S_AVG_DIV, S_REM_DIV, S_SOC_DIV, S_CHG_DIV, S_DIS_DIV: begin
                if (ld) begin
                    r_dquo <= '0;
                    case (r_state)
                        S_AVG_DIV: begin
                            r_dneg  <= r_wsum[SW-1];
                            r_dpart <= '0;
                            r_dnum  <= ACC_W'(sum_mag) << (ACC_W - SW);
                            r_dden  <= CHG_W'(r_wcount);
                        end
                        S_REM_DIV: begin
                            r_dpart <= CHG_W'(ACC_W'(r_rem) >> REM_QB);
                            r_dnum  <= ACC_W'(r_rem) << (ACC_W - REM_QB);
                            r_dden  <= UNITS_PER_MAH;
                        end
                        S_SOC_DIV: begin
                            r_out_rem <= r_dquo[CAP_W-1:0];
                            r_dpart   <= CHG_W'(rem_k >> SOC_QB);
                            r_dnum    <= rem_k << (ACC_W - SOC_QB);
                            r_dden    <= r_cap_units;
                        end
                        S_CHG_DIV: begin
                            r_out_soc <= (r_dquo[SOC_QB-1:0] > SOC_QB'(SOC_FULL))
                                         ? SOC_FULL : r_dquo[SOC_W-1:0];
                            r_dpart   <= CHG_W'(r_chg >> TOT_QB);
                            r_dnum    <= r_chg << (ACC_W - TOT_QB);
                            r_dden    <= UNITS_PER_MAH;
                        end
                        default: begin
                            r_out_chg <= (r_dquo[QUO_W-1:TOT_W] != '0) ? '1
                                                                        : r_dquo[TOT_W-1:0];
                            r_dpart   <= CHG_W'(r_dis >> TOT_QB);
                            r_dnum    <= r_dis << (ACC_W - TOT_QB);
                            r_dden    <= UNITS_PER_MAH;
                        end
                    endcase
                end else begin
                    r_dpart <= d_ge ? d_diff[CHG_W-1:0] : d_t[CHG_W-1:0];
                    r_dnum  <= r_dnum << 1;
                    r_dquo  <= {r_dquo[QUO_W-2:0], d_ge};
                end
            end
            default: begin
                r_dneg <= r_dneg;
            end
        endcase
    end

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = cfg_ready;

    assign o_out.valid               = out_valid;
    assign o_out.remaining_mah       = r_out_rem;
    assign o_out.soc_permille        = r_out_soc;
    assign o_out.filtered_current_ma = r_avg;
    assign o_out.charged_mah         = r_out_chg;
    assign o_out.discharged_mah      = out_dis;
    assign o_out.calibrated_full     = r_cal;
    assign o_out.cutoff_empty        = r_cut;

    `BCC_ASSERT_IMP(a_rem_cap, i_clk, i_rst_n, r_state == S_DONE, r_rem <= r_cap_units)
    `BCC_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, out_valid, !(r_cal && r_cut))
    `BCC_ASSERT_IMP(a_soc_max, i_clk, i_rst_n, out_valid, r_out_soc <= SOC_FULL)
    `BCC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    `BCC_ASSERT_IMP(a_count_max, i_clk, i_rst_n, r_state != S_IDLE, r_wcount <= TAPS_C)

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery coulomb counter testbench
// drives current, voltage, stage and check words through the input channel,
// predicts every result word with a cycle-free model of the gauge and compares
// each field; register settings, idling and back-pressure vary by phase
// ----------------------------------------------------------------------------
module testbench;
    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [CAP_W-1:0]        rem_mah;
        logic [SOC_W-1:0]        soc;
        logic signed [VAL_W-1:0] avg;
        logic [TOT_W-1:0]        chg;
        logic [TOT_W-1:0]        dis;
        logic                    cal;
        logic                    cut;
    } t_gauge_result;

    class gauge_scoreboard;
        localparam int AVG_TAPS_TB = 5;

        longint unsigned mah_units;
        longint unsigned cap, low_mv, float_mv, absorb_mv, max_gap, hold;
        int              win[AVG_TAPS_TB];
        int              win_cnt, win_pos, win_sum, avg;
        longint unsigned charge, chg_tot, dis_tot;
        bit [31:0]       last_t, full_t;
        bit              seen, vseen, full_pend;
        longint unsigned volt;
        int              stage;
        t_gauge_result   gauge_q[$];
        int              errors, mismatches, results, n_cal, n_cut;

        function new();
            mah_units = longint'(UNITS_PER_MAH);
            cap = CAP_RST; low_mv = LOW_MV_RST; float_mv = FLOAT_RST;
            absorb_mv = ABSORB_RST; max_gap = GAP_RST; hold = HOLD_RST;
            foreach (win[k]) win[k] = 0;
            win_cnt = 0; win_pos = 0; win_sum = 0; avg = 0;
            charge = cap * mah_units / 2;
            chg_tot = 0; dis_tot = 0; last_t = 0; full_t = 0;
            seen = 0; vseen = 0; full_pend = 0; volt = 0; stage = 0;
            errors = 0; mismatches = 0; results = 0; n_cal = 0; n_cut = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            longint unsigned val;
            val = data;
            case (idx)
                CFG_CAPACITY: if (val >= 5000) cap = val;
                CFG_LOW_MV: begin
                    val = val & 'hFFFF;
                    if (val >= 18000) low_mv = val;
                end
                CFG_FLOAT_MV: begin
                    val = val & 'h7FFF;
                    if (val >= 20000 && val <= 32000) float_mv = val;
                end
                CFG_ABSORB: begin
                    val = val & 'h7FFF;
                    if (val >= 20000 && val <= 32000) absorb_mv = val;
                end
                CFG_MAX_GAP: max_gap = val & 'hFFFF;
                CFG_HOLD: hold = val;
                default: ;
            endcase
        endfunction

        function longint unsigned sat_add(longint unsigned a, longint unsigned b);
            return (a > ~64'd0 - b) ? ~64'd0 : a + b;
        endfunction

        function logic [TOT_W-1:0] to_mah(longint unsigned t);
            longint unsigned m;
            m = t / mah_units;
            return (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
        endfunction

        function void integrate(bit [31:0] now, int v);
            int         pos;
            longint     i, eff, dq, r;
            bit [31:0]  dt;
            pos = win_pos;
            win_sum = win_sum - win[pos] + v;
            win[pos] = v;
            win_pos = (pos + 1) % AVG_TAPS_TB;
            if (win_cnt < AVG_TAPS_TB) win_cnt++;
            avg = win_sum / win_cnt;
            i = avg;
            if (i > -50 && i < 50) i = 0;
            if (seen) begin
                dt = now - last_t;
                if (dt > 0 && longint'(dt) <= max_gap) begin
                    if (i > 0) eff = (i > 40000) ? 112 : ((i > 15000) ? 106 : 102);
                    else eff = 98;
                    dq = i * eff * longint'(dt);
                    r = longint'(charge) - dq;
                    if (i > 0) dis_tot = sat_add(dis_tot, dq);
                    else chg_tot = sat_add(chg_tot, -dq);
                    if (r < 0) r = 0;
                    if (r > longint'(cap * mah_units)) r = cap * mah_units;
                    charge = r;
                end
            end
            last_t = now;
            seen = 1;
        endfunction

        function bit full_ok();
            longint unsigned tgt;
            if (stage != STAGE_FLOAT && stage != STAGE_ABSORB) return 0;
            if (avg > 1000 || avg < -1000) return 0;
            if (!vseen) return 0;
            tgt = (stage == STAGE_FLOAT) ? float_mv : absorb_mv;
            if (volt + 200 < tgt) return 0;
            if (charge >= cap * mah_units - 10 * mah_units) return 0;
            return 1;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [TS_W-1:0] now,
                                logic signed [VAL_W-1:0] sv);
            t_gauge_result   res;
            int              v;
            longint unsigned cu, soc;
            v = sv;
            res.cal = 0;
            res.cut = 0;
            cu = cap * mah_units;
            if (charge > cu) charge = cu;
            case (op)
                OP_CURRENT: integrate(now, v);
                OP_VOLTAGE: begin
                    volt = (v < 0) ? 0 : v;
                    vseen = 1;
                    if (volt + 200 <= low_mv && avg > 500 && charge > 500 * mah_units) begin
                        charge = 0;
                        res.cut = 1;
                    end
                end
                OP_STAGE: stage = (v < 0 || v > 15) ? STAGE_BAD : v;
                default: begin
                    if (full_ok()) begin
                        if (!full_pend) begin
                            full_pend = 1;
                            full_t = now;
                        end else if (longint'(now - full_t) >= hold) begin
                            charge = cu;
                            full_pend = 0;
                            full_t = 0;
                            res.cal = 1;
                        end
                    end else begin
                        full_pend = 0;
                        full_t = 0;
                    end
                end
            endcase
            soc = charge * 1000 / cu;
            if (soc > 1000) soc = 1000;
            res.rem_mah = CAP_W'(charge / mah_units);
            res.soc = SOC_W'(soc);
            res.avg = VAL_W'(avg);
            res.chg = to_mah(chg_tot);
            res.dis = to_mah(dis_tot);
            gauge_q.push_back(res);
        endfunction

        function void check_word(t_gauge_result got);
            t_gauge_result want;
            if (gauge_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result word at %0t", $realtime);
                return;
            end
            want = gauge_q.pop_front();
            results++;
            n_cal += want.cal;
            n_cut += want.cut;
            if (got.rem_mah !== want.rem_mah || got.soc !== want.soc || got.avg !== want.avg ||
                got.chg !== want.chg || got.dis !== want.dis || got.cal !== want.cal ||
                got.cut !== want.cut) begin
                errors++;
                if (mismatches++ < 10) begin
                    $display("mismatch word %0d exp mah %0d soc %0d avg %0d chg %0d dis %0d cal %0b cut %0b",
                             results, want.rem_mah, want.soc, want.avg, want.chg, want.dis,
                             want.cal, want.cut);
                    $display("                 got mah %0d soc %0d avg %0d chg %0d dis %0d cal %0b cut %0b",
                             got.rem_mah, got.soc, got.avg, got.chg, got.dis, got.cal, got.cut);
                end
            end
        endfunction

        function int outstanding();
            return gauge_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bcc_in_if  in_if ();
    bcc_out_if out_if ();
    bcc_cfg_if cfg_if ();

    battery_coulomb_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    gauge_scoreboard sb = new();
    int        tx_idle = 0;
    int        rx_stall = 0;
    int        holdoff = 0;
    int        n_words = 0;
    int        cycles = 0;
    bit [31:0] t_now = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side
    initial begin
        t_gauge_result got;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got.rem_mah = out_if.remaining_mah;
                got.soc     = out_if.soc_permille;
                got.avg     = out_if.filtered_current_ma;
                got.chg     = out_if.charged_mah;
                got.dis     = out_if.discharged_mah;
                got.cal     = out_if.calibrated_full;
                got.cut     = out_if.cutoff_empty;
                sb.check_word(got);
            end
            if (holdoff > 0) begin
                holdoff--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall);
            end
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [31:0] ts, input int val);
        while ($urandom_range(99) < tx_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.operation    <= op;
        in_if.timestamp_ms <= ts;
        in_if.sample_value <= val[VAL_W-1:0];
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_word(op, ts, val[VAL_W-1:0]);
        n_words++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.write_reg(idx, data[CFG_DATA_W-1:0]);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] next_ts();
        int r;
        int step_max;
        r = $urandom_range(99);
        step_max = (sb.max_gap > 3000) ? 3000 : ((sb.max_gap < 1) ? 1 : int'(sb.max_gap));
        if (r < 8) ;
        else if (r < 11) t_now = t_now + $urandom;
        else if (r < 14) t_now = 32'(t_now + sb.max_gap + $urandom_range(1, 100));
        else if (r < 18) t_now = 32'(t_now + sb.max_gap);
        else t_now = t_now + $urandom_range(1, step_max);
        return t_now;
    endfunction

    function automatic int current_val();
        int r;
        r = $urandom_range(99);
        if (r < 25) return $urandom_range(0, 200) - 100;
        if (r < 55) return $urandom_range(0, 4000) - 2000;
        if (r < 80) return $urandom_range(0, 100000) - 50000;
        return $urandom;
    endfunction

    function automatic int volt_val();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(15000, 33000);
        if (r < 85) return int'(sb.low_mv) - 202 + $urandom_range(0, 4);
        return $urandom;
    endfunction

    function automatic int stage_val();
        int r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(STAGE_FLOAT, STAGE_ABSORB);
        if (r < 85) return $urandom_range(0, 15);
        return $urandom;
    endfunction

    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 50) send(OP_CURRENT, next_ts(), current_val());
        else if (r < 70) send(OP_VOLTAGE, next_ts(), volt_val());
        else if (r < 80) send(OP_STAGE, next_ts(), stage_val());
        else send(OP_CHECK, next_ts(), $urandom);
    endtask

    // charger at float or absorb, small current, then a check, a second one near a hold later and a third just after
    task automatic calib_seq();
        int stg;
        int tgt;
        stg = $urandom_range(STAGE_FLOAT, STAGE_ABSORB);
        tgt = (stg == STAGE_FLOAT) ? int'(sb.float_mv) : int'(sb.absorb_mv);
        send(OP_STAGE, next_ts(), stg);
        send(OP_VOLTAGE, next_ts(), tgt - 200 + $urandom_range(0, 1500));
        repeat ($urandom_range(1, 5)) begin
            t_now = t_now + $urandom_range(1, 50);
            send(OP_CURRENT, t_now, $urandom_range(0, 1200) - 600);
        end
        send(OP_CHECK, t_now, $urandom);
        t_now = 32'(t_now + sb.hold - 1 + $urandom_range(0, 3));
        send(OP_CHECK, t_now, $urandom);
        t_now = t_now + $urandom_range(0, 2);
        send(OP_CHECK, t_now, $urandom);
    endtask

    // heavy load then a sag to the cutoff
    task automatic cutoff_seq();
        repeat (5) begin
            t_now = t_now + $urandom_range(1, 20);
            send(OP_CURRENT, t_now, $urandom_range(600, 60000));
        end
        send(OP_VOLTAGE, next_ts(), int'(sb.low_mv) - 200 - $urandom_range(0, 2000) +
             (($urandom_range(3) == 0) ? 1 : 0));
    endtask

    task automatic run_phase(input int count, input int ph);
        int start;
        int r;
        bit paused;
        start = n_words;
        paused = 0;
        if (ph == 2) holdoff = 3000;
        while (n_words - start < count) begin
            if (ph == 3 && !paused && n_words - start > count / 2) begin
                drain();
                paused = 1;
            end
            r = $urandom_range(99);
            if (r < 15) calib_seq();
            else if (r < 22) cutoff_seq();
            else random_word();
        end
        drain();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_CURRENT;
        in_if.timestamp_ms <= '0;
        in_if.sample_value <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_CAPACITY;
        cfg_if.data     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ordering corner cases, deadzone and efficiency edges
        t_now = 1000;
        send(OP_CHECK, t_now, 0);
        send(OP_VOLTAGE, t_now, -5);
        send(OP_STAGE, t_now, -1);
        send(OP_STAGE, t_now, 16);
        send(OP_CURRENT, t_now, 49);
        t_now += 100;   send(OP_CURRENT, t_now, -49);
        send(OP_CURRENT, t_now, 50);
        t_now += 40000; send(OP_CURRENT, t_now, -50);
        t_now += 1000;  send(OP_CURRENT, t_now, 15000);
        t_now += 1000;  send(OP_CURRENT, t_now, 15001);
        t_now += 1000;  send(OP_CURRENT, t_now, 40000);
        t_now += 1000;  send(OP_CURRENT, t_now, 40001);
        t_now += 1000;  send(OP_CURRENT, t_now, 524287);
        t_now += 1000;  send(OP_CURRENT, t_now, -524288);
        t_now += 1000;  send(OP_VOLTAGE, t_now, 524287);
        repeat (4) begin
            t_now += 10; send(OP_CURRENT, t_now, 0);
        end
        send(OP_STAGE, t_now, STAGE_FLOAT);
        send(OP_VOLTAGE, t_now, 26800);
        send(OP_CHECK, t_now, 0);
        t_now += 60000; send(OP_CHECK, t_now, 0);
        repeat (5) begin
            t_now += 1; send(OP_CURRENT, t_now, 1000);
        end
        send(OP_VOLTAGE, t_now, 20800);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_CAPACITY, 4999);
                    write_reg(CFG_CAPACITY, 5000);
                    write_reg(CFG_LOW_MV, 17999);
                    write_reg(CFG_LOW_MV, 18000);
                    write_reg(CFG_FLOAT_MV, 32001);
                    write_reg(CFG_FLOAT_MV, 20000);
                    write_reg(CFG_ABSORB, 32000);
                    write_reg(CFG_MAX_GAP, 1);
                    write_reg(CFG_HOLD, 1);
                end
                1: begin
                    write_reg(CFG_CAPACITY, 1048575);
                    write_reg(CFG_LOW_MV, 65535);
                    write_reg(CFG_FLOAT_MV, 32000 + 32768);
                    write_reg(CFG_ABSORB, 20000);
                    write_reg(CFG_MAX_GAP, 65535);
                    write_reg(CFG_HOLD, 1048575);
                end
                default: begin
                    write_reg(CFG_CAPACITY, $urandom_range(5000, 1048575));
                    write_reg(CFG_LOW_MV, $urandom_range(18000, 26000));
                    write_reg(CFG_FLOAT_MV, $urandom_range(19990, 32010));
                    write_reg(CFG_ABSORB, $urandom_range(20000, 32000));
                    write_reg(CFG_MAX_GAP, $urandom_range(1000, 65535));
                    write_reg(CFG_HOLD, $urandom_range(1, 20000));
                end
            endcase
            case (ph % 4)
                0: begin tx_idle = 0;  rx_stall = 0;  end
                1: begin tx_idle = 83; rx_stall = 0;  end
                2: begin tx_idle = 0;  rx_stall = 83; end
                default: begin tx_idle = 38; rx_stall = 38; end
            endcase
            if (ph == 4) t_now = 32'hFFFF_0000;
            run_phase(290, ph);
        end

        in_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        sb.errors += sb.outstanding();
        $display("covered %0d words over six register settings, %0d results checked",
                 n_words, sb.results);
        $display("%0d full calibrations, %0d forced empties, %0d errors",
                 sb.n_cal, sb.n_cut, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
